// ----- hdl/rrcc_pkg.sv -----
// Shared types and constants of the resource range conflict checker.
// Depends on nothing; every module of the block imports it.
`timescale 1ns / 1ps

package rrcc_pkg;

    // Field widths fixed by the item format.
    localparam int unsigned ENTRY_INDEX_W = 6;
    localparam int unsigned BOARD_W       = 6;
    localparam int unsigned RES_TYPE_W    = 3;
    localparam int unsigned ADDR_W        = 32;

    // Table slots the 6-bit entry index can reach.
    localparam int unsigned INDEX_SLOTS       = 2 ** ENTRY_INDEX_W;
    localparam int unsigned DEF_TABLE_ENTRIES = 64;

    // Configuration port.
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned PORT_MAX_W  = 16;
    localparam int unsigned COUNT_W     = 9;

    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PORT  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IRQ_COUNT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DMA_COUNT = 2'd2;

    localparam logic [PORT_MAX_W-1:0] RST_MAX_PORT  = 16'hFFFF;
    localparam logic [COUNT_W-1:0]    RST_IRQ_COUNT = 9'd16;
    localparam logic [COUNT_W-1:0]    RST_DMA_COUNT = 9'd8;

    // Actions.
    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;

    // Resource types.
    localparam logic [RES_TYPE_W-1:0] RT_PORT = 3'd0;
    localparam logic [RES_TYPE_W-1:0] RT_IRQ  = 3'd1;
    localparam logic [RES_TYPE_W-1:0] RT_DMA  = 3'd2;
    localparam logic [RES_TYPE_W-1:0] RT_MEM  = 3'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_RANGE    = 2'd1;
    localparam logic [1:0] ST_BAD_TYPE = 2'd2;

    typedef struct packed {
        logic [1:0]               action;
        logic [ENTRY_INDEX_W-1:0] entry_index;
        logic [BOARD_W-1:0]       owner_board;
        logic [RES_TYPE_W-1:0]    res_type;
        logic                     alternate_mark;
        logic                     shared_mark;
        logic                     weak_mark;
        logic                     usurp_request;
        logic [ADDR_W-1:0]        range_base;
        logic [ADDR_W-1:0]        range_length;
    } t_in_item;

    typedef struct packed {
        logic               conflict_found;
        logic [BOARD_W-1:0] conflict_board;
        logic [1:0]         status;
    } t_out_item;

    // One table record; the range end is stored as the wrapped base + length.
    typedef struct packed {
        logic [BOARD_W-1:0]    owner_board;
        logic [RES_TYPE_W-1:0] res_type;
        logic                  alternate_mark;
        logic                  shared_mark;
        logic                  weak_mark;
        logic [ADDR_W-1:0]     range_base;
        logic [ADDR_W-1:0]     range_end;
    } t_entry;

endpackage

// ----- hdl/resource_range_conflict_checker_top.sv -----
// Top level of the resource range conflict checker: FSM, record memory and
// valid bits. Depends on rrcc_pkg.
`timescale 1ns / 1ps

// Usage
// Items arrive on the input channel (i_in_valid / o_in_ready, payload
// i_in_item) and each one produces exactly one result on the output channel
// (o_out_valid / i_out_ready, payload o_out_item). Registers are to be written
// through i_cfg_we / i_cfg_index / i_cfg_data only while the block is idle; the user
// is bound by this, the block itself does not enforce it. The block works on one item at a time.
// A clear, a write, an unused action or a query rejected by the range check
// goes from the execute state to the finish state without a scan.
// A query that passes the check walks the record memory one entry per cycle
// through its single read port and stops at the first conflict or after the
// last entry, then moves to the finish state.
// The finished result sits in an output register; the block may take the
// next item while it waits, but does not overwrite it until the receiver
// takes the transfer. Reset invalidates every table entry at once and loads
// the register defaults; no clearing pass is needed.
module resource_range_conflict_checker_top #(
    parameter int unsigned TABLE_ENTRIES = rrcc_pkg::DEF_TABLE_ENTRIES
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  rrcc_pkg::t_in_item                  i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output rrcc_pkg::t_out_item                 o_out_item,
    input  logic                                i_cfg_we,
    input  logic [rrcc_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [rrcc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import rrcc_pkg::*;

    // Only slots the entry index can address need storage.
    localparam int unsigned DEPTH = (TABLE_ENTRIES < INDEX_SLOTS) ? TABLE_ENTRIES
                                                                   : INDEX_SLOTS;
    localparam int unsigned AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_FIN
    } t_state;

    t_state              r_state;
    t_in_item            r_item;
    logic [ADDR_W-1:0]   r_q_end;
    t_out_item           r_res;
    t_out_item           r_out;
    logic                r_out_valid;
    logic [DEPTH-1:0]    r_valid;
    logic [AW-1:0]       r_scan_addr;
    logic                r_issue_done;
    logic                r_pipe_vld;
    logic                r_pipe_last;
    logic                r_pipe_entry_ok;

    logic [PORT_MAX_W-1:0] r_max_port;
    logic [COUNT_W-1:0]    r_irq_count;
    logic [COUNT_W-1:0]    r_dma_count;

    t_entry              r_mem [DEPTH];
    t_entry              r_rd_data;
    t_entry              n_wr_data;
    logic                n_mem_we;
    logic                n_mem_re;
    logic                n_index_ok;

    logic [ADDR_W-1:0]   n_last_addr;
    logic [1:0]          n_status;
    logic                n_hit;
    logic                n_overlap;
    logic                n_scan_go;
    logic                n_scan_end;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Range check on the captured query.
    always_comb begin
        n_last_addr = r_item.range_base + r_item.range_length - ADDR_W'(1);
        case (r_item.res_type)
            RT_PORT: n_status = (n_last_addr > ADDR_W'(r_max_port))  ? ST_RANGE : ST_OK;
            RT_IRQ:  n_status = (n_last_addr >= ADDR_W'(r_irq_count)) ? ST_RANGE : ST_OK;
            RT_DMA:  n_status = (n_last_addr >= ADDR_W'(r_dma_count)) ? ST_RANGE : ST_OK;
            RT_MEM:  n_status = ST_OK;
            default: n_status = ST_BAD_TYPE;
        endcase
    end

    // Match test on the entry read in the previous cycle.
    always_comb begin
        n_overlap = ((r_item.range_base >= r_rd_data.range_base) &&
                     (r_item.range_base < r_rd_data.range_end)) ||
                    ((r_rd_data.range_base >= r_item.range_base) &&
                     (r_rd_data.range_base < r_q_end));
        n_hit = r_pipe_vld && r_pipe_entry_ok && n_overlap &&
                !(r_item.shared_mark && r_rd_data.shared_mark) &&
                (r_rd_data.res_type == r_item.res_type) &&
                (r_rd_data.alternate_mark == r_item.alternate_mark) &&
                !(r_item.usurp_request && r_rd_data.weak_mark);
    end

    assign n_scan_go  = (r_item.action == ACT_QUERY) && (n_status == ST_OK);
    assign n_scan_end = n_hit || (r_pipe_vld && r_pipe_last);

    assign n_index_ok = (int'(r_item.entry_index) < int'(DEPTH));
    assign n_mem_we   = (r_state == S_EXEC) && (r_item.action == ACT_WRITE) && n_index_ok;
    assign n_mem_re   = (r_state == S_SCAN) && !r_issue_done;

    always_comb begin
        n_wr_data.owner_board    = r_item.owner_board;
        n_wr_data.res_type       = r_item.res_type;
        n_wr_data.alternate_mark = r_item.alternate_mark;
        n_wr_data.shared_mark    = r_item.shared_mark;
        n_wr_data.weak_mark      = r_item.weak_mark;
        n_wr_data.range_base     = r_item.range_base;
        n_wr_data.range_end      = r_item.range_base + r_item.range_length;
    end

    // Record memory. Writes and scan reads never share a cycle, since only one
    // item is in flight.
    always_ff @(posedge i_clk) begin
        if (n_mem_we) begin
            r_mem[r_item.entry_index[AW-1:0]] <= n_wr_data;
        end
        if (n_mem_re) begin
            r_rd_data <= r_mem[r_scan_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_port  <= RST_MAX_PORT;
            r_irq_count <= RST_IRQ_COUNT;
            r_dma_count <= RST_DMA_COUNT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MAX_PORT:  r_max_port  <= i_cfg_data[PORT_MAX_W-1:0];
                CFG_IRQ_COUNT: r_irq_count <= i_cfg_data[COUNT_W-1:0];
                CFG_DMA_COUNT: r_dma_count <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_valid      <= '0;
            r_issue_done <= 1'b1;
            r_pipe_vld   <= 1'b0;
        end else begin
            // The finish state always leaves a result in the output register.
            r_out_valid <= (r_state == S_FIN) || (r_out_valid && !i_out_ready);

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_item  <= i_in_item;
                        r_q_end <= i_in_item.range_base + i_in_item.range_length;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_res   <= '{conflict_found: 1'b0, conflict_board: '0,
                                 status: (r_item.action == ACT_QUERY) ? n_status : ST_OK};
                    r_state <= n_scan_go ? S_SCAN : S_FIN;
                    case (r_item.action)
                        ACT_CLEAR: r_valid <= '0;
                        ACT_WRITE: begin
                            if (n_index_ok) begin
                                r_valid[r_item.entry_index[AW-1:0]] <= 1'b1;
                            end
                        end
                        default: ;
                    endcase
                    if (n_scan_go) begin
                        r_scan_addr  <= '0;
                        r_issue_done <= 1'b0;
                        r_pipe_vld   <= 1'b0;
                    end
                end
                S_SCAN: begin
                    // Read slot k while judging slot k-1.
                    r_pipe_vld      <= !r_issue_done && !n_scan_end;
                    r_pipe_last     <= (r_scan_addr == LAST_ADDR);
                    r_pipe_entry_ok <= r_valid[r_scan_addr];
                    r_issue_done    <= r_issue_done || n_scan_end ||
                                       (r_scan_addr == LAST_ADDR);
                    if (!r_issue_done && (r_scan_addr != LAST_ADDR)) begin
                        r_scan_addr <= r_scan_addr + AW'(1);
                    end
                    if (n_hit) begin
                        r_res.conflict_found <= 1'b1;
                        r_res.conflict_board <= r_rd_data.owner_board;
                    end
                    if (n_scan_end) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // A rejected query never reports a conflict.
    a_status_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.status != ST_OK)) |-> !o_out_item.conflict_found)
        else $error("conflict reported on a rejected query");

    // With no conflict the board field is zero.
    a_board_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.conflict_found) |-> (o_out_item.conflict_board == '0))
        else $error("nonzero board without conflict");

    // A new result is only loaded from the finish state.
    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_FIN))
        else $error("result appeared outside the finish state");

    // Memory reads happen only during a scan and never alongside a write.
    a_mem_ports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_mem_re |-> (!n_mem_we && (r_item.action == ACT_QUERY)))
        else $error("record memory accessed outside a query scan");

endmodule

// ----- test/tb_resource_range_conflict_checker_top.sv -----
// Self-checking testbench for resource_range_conflict_checker_top: random and directed
// table writes, clears and range queries against a built-in table predictor.
// Depends on rrcc_pkg and the top-level RTL.
`timescale 1ns / 1ps

module tb_resource_range_conflict_checker_top;
    import rrcc_pkg::*;

    localparam int unsigned TABLE_SLOTS = DEF_TABLE_ENTRIES;
    localparam int unsigned PHASE_ITEMS = 365;
    localparam int unsigned IDLE_LIMIT  = 3000;
    localparam int unsigned RECENT_MAX  = 16;

    // Codes the package leaves unnamed.
    localparam logic [1:0]             ACT_SPARE  = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [BOARD_W-1:0]    owner;
        logic [RES_TYPE_W-1:0] kind;
        logic                  alt;
        logic                  shr;
        logic                  weak_bit;
        logic [ADDR_W-1:0]     base;
        logic [ADDR_W-1:0]     span;
    } t_record;

    logic                   i_clk;
    logic                   i_rst_n     = 1'b0;
    logic                   i_in_valid  = 1'b0;
    logic                   o_in_ready;
    t_in_item               i_in_item   = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    t_out_item              o_out_item;
    logic                   i_cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = CFG_MAX_PORT;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;

    // Predictor copy of the block's registers and table.
    logic [PORT_MAX_W-1:0] cfg_max_port     = RST_MAX_PORT;
    logic [COUNT_W-1:0]    cfg_irq_lines    = RST_IRQ_COUNT;
    logic [COUNT_W-1:0]    cfg_dma_channels = RST_DMA_COUNT;
    t_record               records [TABLE_SLOTS];
    logic                  record_live [TABLE_SLOTS];

    t_in_item  pending_requests[$];
    t_in_item  recent_writes[$];
    t_out_item expected_results[$];

    int unsigned error_count   = 0;
    int unsigned idle_cycles   = 0;
    int unsigned gap_left      = 0;
    int unsigned hold_left     = 0;
    int unsigned sent_count    = 0;
    int unsigned results_seen  = 0;
    bit          feed_calm     = 1'b0;
    bit          drain_calm    = 1'b0;

    resource_range_conflict_checker_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            record_live[i] = 1'b0;
            records[i]     = '0;
        end
    end

    function automatic logic [1:0] range_verdict(t_in_item rq);
        logic [ADDR_W-1:0] last;
        last = rq.range_base + rq.range_length - 32'd1;
        case (rq.res_type)
            RT_PORT: return (last > cfg_max_port) ? ST_RANGE : ST_OK;
            RT_IRQ:  return (last >= cfg_irq_lines) ? ST_RANGE : ST_OK;
            RT_DMA:  return (last >= cfg_dma_channels) ? ST_RANGE : ST_OK;
            RT_MEM:  return ST_OK;
            default: return ST_BAD_TYPE;
        endcase
    endfunction

    // Applies one request to the predicted table and returns the result it must give.
    function automatic t_out_item resolve_request(t_in_item rq);
        t_out_item         res;
        logic [ADDR_W-1:0] rec_end;
        logic [ADDR_W-1:0] req_end;
        logic              overlap;
        res = '0;
        case (rq.action)
            ACT_CLEAR: begin
                for (int i = 0; i < TABLE_SLOTS; i++) record_live[i] = 1'b0;
            end
            ACT_WRITE: begin
                if (rq.entry_index < TABLE_SLOTS) begin
                    record_live[rq.entry_index] = 1'b1;
                    records[rq.entry_index] = '{owner: rq.owner_board, kind: rq.res_type,
                                                alt: rq.alternate_mark, shr: rq.shared_mark,
                                                weak_bit: rq.weak_mark, base: rq.range_base,
                                                span: rq.range_length};
                end
            end
            ACT_QUERY: begin
                res.status = range_verdict(rq);
                if (res.status == ST_OK) begin
                    req_end = rq.range_base + rq.range_length;
                    for (int i = 0; i < TABLE_SLOTS; i++) begin
                        rec_end = records[i].base + records[i].span;
                        overlap = (rq.range_base >= records[i].base && rq.range_base < rec_end) ||
                                  (records[i].base >= rq.range_base && records[i].base < req_end);
                        // Shared requests pass shared records; usurpers pass weak ones.
                        if (record_live[i] && !(rq.shared_mark && records[i].shr) &&
                            records[i].kind == rq.res_type &&
                            records[i].alt == rq.alternate_mark && overlap &&
                            !(rq.usurp_request && records[i].weak_bit)) begin
                            res.conflict_found = 1'b1;
                            res.conflict_board = records[i].owner;
                            break;
                        end
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic t_in_item request(logic [1:0] act, int idx, int owner,
                                         logic [RES_TYPE_W-1:0] kind, bit alt, bit shr,
                                         bit weak_bit, bit usurp, logic [ADDR_W-1:0] base,
                                         logic [ADDR_W-1:0] len);
        t_in_item rq;
        rq.action         = act;
        rq.entry_index    = idx[ENTRY_INDEX_W-1:0];
        rq.owner_board    = owner[BOARD_W-1:0];
        rq.res_type       = kind;
        rq.alternate_mark = alt;
        rq.shared_mark    = shr;
        rq.weak_mark      = weak_bit;
        rq.usurp_request  = usurp;
        rq.range_base     = base;
        rq.range_length   = len;
        return rq;
    endfunction

    function automatic logic [RES_TYPE_W-1:0] pick_kind();
        if ($urandom_range(0, 15) == 0) return RES_TYPE_W'($urandom_range(4, 7));
        return RES_TYPE_W'($urandom_range(0, 3));
    endfunction

    // Mostly ranges that fit the current limits and cluster so that overlaps are common.
    function automatic void shape_range(input logic [RES_TYPE_W-1:0] kind,
                                        output logic [ADDR_W-1:0] base,
                                        output logic [ADDR_W-1:0] len);
        int unsigned lim;
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            base = $urandom;
            len  = $urandom;
            return;
        end
        case (kind)
            RT_PORT: begin
                lim = cfg_max_port;
                if (r < 25) base = lim - $urandom_range(0, (lim < 15) ? lim : 15);
                else        base = $urandom_range(0, (lim < 255) ? lim : 255);
                len = (r >= 95) ? 0 : $urandom_range(1, 8);
            end
            RT_IRQ, RT_DMA: begin
                lim  = (kind == RT_IRQ) ? cfg_irq_lines : cfg_dma_channels;
                base = $urandom_range(0, lim - 1);
                len  = $urandom_range(1, lim - base);
                if (r < 20) len = len + 1;
            end
            RT_MEM: begin
                base = (r < 30) ? 32'hFFFF_FF00 + $urandom_range(0, 255) : $urandom_range(0, 1023);
                len  = (r >= 90) ? $urandom : $urandom_range(0, 300);
            end
            default: begin
                base = $urandom_range(0, 255);
                len  = $urandom_range(0, 16);
            end
        endcase
    endfunction

    function automatic t_in_item random_request();
        t_in_item    rq;
        t_in_item    prior;
        int unsigned r;
        rq.action         = ACT_SPARE;
        rq.entry_index    = ENTRY_INDEX_W'($urandom_range(0, 63));
        rq.owner_board    = BOARD_W'($urandom_range(0, 63));
        rq.res_type       = RES_TYPE_W'($urandom_range(0, 7));
        rq.alternate_mark = 1'($urandom_range(0, 1));
        rq.shared_mark    = ($urandom_range(0, 3) == 0);
        rq.weak_mark      = ($urandom_range(0, 2) == 0);
        rq.usurp_request  = ($urandom_range(0, 3) == 0);
        rq.range_base     = $urandom;
        rq.range_length   = $urandom;
        r = $urandom_range(0, 99);
        if (r < 3) begin
            rq.action = ACT_CLEAR;
        end else if (r < 40) begin
            rq.action   = ACT_WRITE;
            rq.res_type = pick_kind();
            shape_range(rq.res_type, rq.range_base, rq.range_length);
            recent_writes.push_back(rq);
            if (recent_writes.size() > RECENT_MAX) void'(recent_writes.pop_front());
        end else if (r < 93) begin
            rq.action = ACT_QUERY;
            if (recent_writes.size() != 0 && $urandom_range(0, 9) < 6) begin
                // Aim the query at a recently written record.
                prior = recent_writes[$urandom_range(0, recent_writes.size() - 1)];
                rq.res_type       = prior.res_type;
                rq.alternate_mark = ($urandom_range(0, 7) == 0) ? ~prior.alternate_mark
                                                               : prior.alternate_mark;
                rq.range_base     = prior.range_base + $urandom_range(0, 8) - 32'd4;
                rq.range_length   = $urandom_range(1, 8);
            end else begin
                rq.res_type = pick_kind();
                shape_range(rq.res_type, rq.range_base, rq.range_length);
            end
        end else if (r >= 96) begin
            rq.action = 2'($urandom_range(0, 3));
        end
        return rq;
    endfunction

    task automatic write_register(logic [CFG_INDEX_W-1:0] idx, int unsigned value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[CFG_DATA_W-1:0];
        case (idx)
            CFG_MAX_PORT:  cfg_max_port     = value[PORT_MAX_W-1:0];
            CFG_IRQ_COUNT: cfg_irq_lines    = value[COUNT_W-1:0];
            CFG_DMA_COUNT: cfg_dma_channels = value[COUNT_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_requests.size() != 0 || expected_results.size() != 0 || i_in_valid)
            @(negedge i_clk);
    endtask

    task automatic compare_field(string label, int unsigned want, int unsigned got);
        if (want != got) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
        end
    endtask

    // Stimulus and phase sequencing.
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        pending_requests.push_back(request(ACT_QUERY, 0, 0, RT_PORT, 0, 0, 0, 0, 'h100, 'h10));
        pending_requests.push_back(request(ACT_WRITE, 0, 5, RT_PORT, 0, 0, 0, 0, 'h100, 'h10));
        pending_requests.push_back(request(ACT_QUERY, 0, 0, RT_PORT, 0, 0, 0, 0, 'h108, 4));
        pending_requests.push_back(request(ACT_QUERY, 0, 0, RT_PORT, 0, 0, 0, 0, 'hF0, 'h20));
        pending_requests.push_back(request(ACT_QUERY, 0, 0, RT_PORT, 0, 0, 0, 0, 'h110, 4));
        pending_requests.push_back(request(ACT_QUERY, 0, 0, RT_PORT, 1, 0, 0, 0, 'h100, 1));
        pending_requests.push_back(request(ACT_WRITE, 1, 9, RT_PORT, 0, 0, 0, 0, 'h104, 4));
        pending_requests.push_back(request(ACT_QUERY, 0, 0, RT_PORT, 0, 0, 0, 0, 'h104, 1));
        pending_requests.push_back(request(ACT_WRITE, 2, 33, RT_PORT, 0, 1, 1, 0, 'h200, 8));
        pending_requests.push_back(request(ACT_QUERY, 0, 0, RT_PORT, 0, 1, 0, 0, 'h200, 1));
        pending_requests.push_back(request(ACT_QUERY, 0, 0, RT_PORT, 0, 0, 0, 1, 'h204, 1));
        pending_requests.push_back(request(ACT_QUERY, 0, 0, RT_PORT, 0, 0, 0, 0, 'h204, 1));
        pending_requests.push_back(request(ACT_QUERY, 0, 0, RT_IRQ, 0, 0, 0, 0, 15, 1));
        pending_requests.push_back(request(ACT_QUERY, 0, 0, RT_IRQ, 0, 0, 0, 0, 15, 2));
        pending_requests.push_back(request(ACT_QUERY, 0, 0, RT_DMA, 0, 0, 0, 0, 0, 9));
        pending_requests.push_back(request(ACT_QUERY, 0, 0, RT_DMA, 0, 0, 0, 0, 7, 1));
        pending_requests.push_back(request(ACT_QUERY, 0, 0, RT_PORT, 0, 0, 0, 0, 'hFFFF, 1));
        pending_requests.push_back(request(ACT_QUERY, 0, 0, RT_PORT, 0, 0, 0, 0, 'hFFFF, 2));
        // A zero length wraps the last address to the top of the address space.
        pending_requests.push_back(request(ACT_QUERY, 0, 0, RT_PORT, 0, 0, 0, 0, 0, 0));
        pending_requests.push_back(request(ACT_QUERY, 63, 63, 3'd7, 1, 1, 1, 1,
                                           '1, '1));
        pending_requests.push_back(request(ACT_WRITE, 63, 63, RT_MEM, 1, 1, 1, 0,
                                           'hFFFF_FFF0, 'h20));
        pending_requests.push_back(request(ACT_QUERY, 0, 0, RT_MEM, 1, 0, 0, 0,
                                           'hFFFF_FFF8, 4));
        pending_requests.push_back(request(ACT_SPARE, 63, 63, 3'd7, 1, 1, 1, 1, '1, '1));
        pending_requests.push_back(request(ACT_CLEAR, 0, 0, RT_PORT, 0, 0, 0, 0, 0, 0));
        pending_requests.push_back(request(ACT_QUERY, 0, 0, RT_PORT, 0, 0, 0, 0, 'h100, 1));

        for (int ph = 0; ph < 5; ph++) begin
            if (ph != 0) begin
                wait_drained();
                case (ph)
                    1: begin
                        write_register(CFG_MAX_PORT, 0);
                        write_register(CFG_IRQ_COUNT, 1);
                        write_register(CFG_DMA_COUNT, 1);
                    end
                    2: begin
                        write_register(CFG_MAX_PORT, 65535);
                        write_register(CFG_IRQ_COUNT, 256);
                        write_register(CFG_DMA_COUNT, 256);
                    end
                    3: begin
                        write_register(CFG_MAX_PORT, $urandom_range(0, 65535));
                        write_register(CFG_IRQ_COUNT, $urandom_range(1, 256));
                        write_register(CFG_DMA_COUNT, $urandom_range(1, 256));
                        write_register(CFG_UNUSED, $urandom_range(0, 65535));
                    end
                    default: begin
                        write_register(CFG_MAX_PORT, $urandom_range(16, 1023));
                        write_register(CFG_IRQ_COUNT, $urandom_range(2, 32));
                        write_register(CFG_DMA_COUNT, $urandom_range(2, 16));
                    end
                endcase
                @(negedge i_clk);
            end
            for (int n = 0; n < PHASE_ITEMS; n++) pending_requests.push_back(random_request());
        end

        wait_drained();
        repeat (TABLE_SLOTS + 8) @(posedge i_clk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Input side: presents queued requests and predicts each one as it transfers.
    always @(posedge i_clk) begin : feeder
        int unsigned r;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expected_results.push_back(resolve_request(i_in_item));
                sent_count++;
                if (sent_count % 40 == 0) feed_calm = ($urandom_range(0, 3) == 0);
                r = $urandom_range(0, 99);
                if (feed_calm || r < 65) gap_left = 0;
                else if (r < 92)         gap_left = $urandom_range(1, 4);
                else                     gap_left = $urandom_range(15, 60);
            end
            if (i_in_valid && !o_in_ready) begin
                // Hold the current transfer until it is taken.
            end else if (gap_left != 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
                i_in_valid <= 1'b1;
                i_in_item  <= pending_requests.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output side: random back-pressure and result checking.
    always @(posedge i_clk) begin : result_check
        t_out_item   want;
        int unsigned r;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (results_seen % 80 == 0) drain_calm = ($urandom_range(0, 3) == 0);
                if (expected_results.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result, expected none, actual %p",
                             $time, o_out_item);
                end else begin
                    want = expected_results.pop_front();
                    compare_field("conflict_found", want.conflict_found,
                                  o_out_item.conflict_found);
                    compare_field("conflict_board", want.conflict_board,
                                  o_out_item.conflict_board);
                    compare_field("status", want.status, o_out_item.status);
                end
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if (!drain_calm) begin
                    r = $urandom_range(0, 99);
                    if (r >= 97)      hold_left = $urandom_range(20, 90);
                    else if (r >= 80) hold_left = $urandom_range(1, 3);
                end
            end
        end
    end

    // Ends a hung run: counts cycles in which neither channel completes a transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
